FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the conversion core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2Q_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/e2q_pkg.sv
// Shared types, widths and constants of the Euler-to-quaternion core.
`timescale 1ns / 1ps

package e2q_pkg;

  // Port field widths.
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;

  // Internal datapath widths.
  localparam int RAW_W = 32;  // angle bits before scaling to the accumulator
  localparam int CW    = 35;  // CORDIC vector, signed Q32 with headroom
  localparam int ZW    = 36;  // CORDIC angle accumulator, full turn is 2^33
  localparam int SC_W  = 32;  // sine and cosine, signed Q30
  localparam int PW    = 64;  // product of two Q30 values
  localparam int QW    = 66;  // sum of two Q60 terms with headroom

  // Lane and component indexes.
  localparam int NUM_AXES = 3;
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;
  localparam int NUM_QUAT = 4;
  localparam int QC_X     = 0;
  localparam int QC_Y     = 1;
  localparam int QC_Z     = 2;
  localparam int QC_W     = 3;

  // Reciprocal of the CORDIC gain in Q32.
  localparam logic signed [CW-1:0] CORDIC_K_Q32 = 35'sd2608131496;

  // Rounding of Q32 to Q30 and of a Q60 product to Q30.
  localparam int                   SC_SHIFT = 2;
  localparam logic signed [CW-1:0] SC_RND   = 35'sd2;
  localparam int                   AB_SHIFT = 30;
  localparam logic signed [PW-1:0] AB_RND   = 64'sd536870912;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // One rotation lane: vector and residual angle.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  typedef rot_t [NUM_AXES-1:0] triad_t;

  // Beat moving along the CORDIC cell chain.
  typedef struct packed {
    logic   valid;
    triad_t lanes;
  } cell_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] w;
  } quat_t;

  // Finished result beat leaving the arithmetic pipeline.
  typedef struct packed {
    logic  valid;
    quat_t quat;
  } quat_beat_t;

endpackage

FILE: rtl/core/e2q_angle_if.sv
// Input channel carrying roll, pitch and yaw angles.
`timescale 1ns / 1ps

interface e2q_angle_if;
  logic                             valid;
  logic                             ready;
  logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

FILE: rtl/core/e2q_quat_if.sv
// Result channel carrying the four quaternion components.
`timescale 1ns / 1ps

interface e2q_quat_if;
  logic                             valid;
  logic                             ready;
  logic signed [e2q_pkg::OUT_W-1:0] quat_x;
  logic signed [e2q_pkg::OUT_W-1:0] quat_y;
  logic signed [e2q_pkg::OUT_W-1:0] quat_z;
  logic signed [e2q_pkg::OUT_W-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

FILE: rtl/core/euler_to_quaternion.sv
// Top level: roll/pitch/yaw binary angles to a unit quaternion in Q2.14.
//
//   Channel  Direction  Fields                                  Beat taken when
//   in_if    sink       roll_angle, pitch_angle, yaw_angle      valid && ready
//   out_if   source     quat_x, quat_y, quat_z, quat_w          valid && ready
//
// One beat can enter every cycle while in_if.ready is high; each beat passes the
// CORDIC cell chain (one cell per stage), the seven-stage product pipeline and the
// output register. Reset (rst_n low, synchronous) clears only the valid flags.
// The whole pipeline advances as one; a stalled output parks one beat in a skid
// register, and in_if.ready drops only while that skid register is full.
`timescale 1ns / 1ps

module euler_to_quaternion #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  e2q_angle_if.sink         in_if,
  e2q_quat_if.source        out_if
);

  logic                        en;
  e2q_pkg::cell_beat_t         entry_beat;
  e2q_pkg::cell_beat_t         chain [CORDIC_STAGES+1];
  e2q_pkg::quat_beat_t         p_beat;
  e2q_pkg::quat_beat_t         out_beat;
  logic [e2q_pkg::ANGLE_W-1:0] ang [e2q_pkg::NUM_AXES];

  assign ang[e2q_pkg::AX_ROLL]  = in_if.roll_angle;
  assign ang[e2q_pkg::AX_PITCH] = in_if.pitch_angle;
  assign ang[e2q_pkg::AX_YAW]   = in_if.yaw_angle;

  assign in_if.ready = en;

  // Scale each angle to a half-angle on the accumulator and seed the vectors.
  always_comb begin
    logic [e2q_pkg::RAW_W-1:0]    raw;
    logic signed [e2q_pkg::ZW-1:0] z0;
    entry_beat.valid = in_if.valid;
    for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
      raw = e2q_pkg::RAW_W'(ang[a]);
      z0  = e2q_pkg::ZW'($signed(raw[ANGLE_BITS-1:0]));
      z0  = z0 <<< (e2q_pkg::RAW_W - ANGLE_BITS);
      entry_beat.lanes[a].x = e2q_pkg::CORDIC_K_Q32;
      entry_beat.lanes[a].y = '0;
      entry_beat.lanes[a].z = z0;
    end
  end

  assign chain[0] = entry_beat;

  // Chain of CORDIC cells, one rotation step each.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    e2q_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  // Products, sums and saturation.
  e2q_quat_math #(
    .FRAC_BITS (FRAC_BITS)
  ) u_math (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .beat_in  (chain[CORDIC_STAGES]),
    .beat_out (p_beat)
  );

  // Output register and skid stage.
  e2q_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_beat    (p_beat),
    .p_ready   (en),
    .out_beat  (out_beat),
    .out_ready (out_if.ready)
  );

  assign out_if.valid  = out_beat.valid;
  assign out_if.quat_x = out_beat.quat.x;
  assign out_if.quat_y = out_beat.quat.y;
  assign out_if.quat_z = out_beat.quat.z;
  assign out_if.quat_w = out_beat.quat.w;

endmodule

FILE: rtl/core/e2q_cordic_cell.sv
// One CORDIC rotation cell, working on the three angle lanes at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module e2q_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  e2q_pkg::cell_beat_t beat_in,
  output e2q_pkg::cell_beat_t beat_out
);

  // Doubled arctangent step of this cell.
  localparam logic signed [e2q_pkg::ZW-1:0] DA =
    e2q_pkg::ZW'({e2q_pkg::ATAN_TURN32[STAGE], 1'b0});

  logic             valid_r;
  e2q_pkg::triad_t  lanes_r;
  e2q_pkg::triad_t  lanes_nxt;

  // Rotate each lane toward a zero residual; zero counts as positive.
  always_comb begin
    lanes_nxt = beat_in.lanes;
    for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
      if (!beat_in.lanes[a].z[e2q_pkg::ZW-1]) begin
        lanes_nxt[a].x = beat_in.lanes[a].x - (beat_in.lanes[a].y >>> STAGE);
        lanes_nxt[a].y = beat_in.lanes[a].y + (beat_in.lanes[a].x >>> STAGE);
        lanes_nxt[a].z = beat_in.lanes[a].z - DA;
      end else begin
        lanes_nxt[a].x = beat_in.lanes[a].x + (beat_in.lanes[a].y >>> STAGE);
        lanes_nxt[a].y = beat_in.lanes[a].y - (beat_in.lanes[a].x >>> STAGE);
        lanes_nxt[a].z = beat_in.lanes[a].z + DA;
      end
    end
  end

  // Valid flag of the cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= beat_in.valid;
    end
  end

  // Lane data, no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign beat_out.valid = valid_r;
  assign beat_out.lanes = lanes_r;

  // A held beat keeps its data while the chain is stalled.
  `E2Q_ASSERT_NXT(a_cell_hold, clk, rst_n, valid_r && !en, valid_r && $stable(lanes_r), "cell lost a stalled beat")

endmodule

FILE: rtl/core/e2q_quat_math.sv
// Sine/cosine rounding, triple products and saturation of the quaternion.
`timescale 1ns / 1ps

module e2q_quat_math #(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  e2q_pkg::cell_beat_t beat_in,
  output e2q_pkg::quat_beat_t beat_out
);

  localparam int NUM_ST = 7;
  localparam int NUM_T  = 8;
  localparam int SH     = 60 - FRAC_BITS;
  localparam logic signed [e2q_pkg::QW-1:0] RND_Q     = e2q_pkg::QW'(1) << (SH - 1);
  localparam logic signed [e2q_pkg::QW-1:0] ONE_Q     = e2q_pkg::QW'(1) << FRAC_BITS;
  localparam logic signed [e2q_pkg::QW-1:0] NEG_ONE_Q = -ONE_Q;

  logic [NUM_ST-1:0] vld_r;

  logic signed [e2q_pkg::SC_W-1:0] sin_r   [e2q_pkg::NUM_AXES];
  logic signed [e2q_pkg::SC_W-1:0] cos_r   [e2q_pkg::NUM_AXES];
  logic signed [e2q_pkg::SC_W-1:0] sin_nxt [e2q_pkg::NUM_AXES];
  logic signed [e2q_pkg::SC_W-1:0] cos_nxt [e2q_pkg::NUM_AXES];

  logic signed [e2q_pkg::PW-1:0]   m_r    [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::SC_W-1:0] rs1_r, rc1_r, rs2_r, rc2_r;
  logic signed [e2q_pkg::SC_W-1:0] ab_r   [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::SC_W-1:0] ab_nxt [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::PW-1:0]   t_r    [NUM_T];
  logic signed [e2q_pkg::QW-1:0]   sum_r  [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::QW-1:0]   rs_r   [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::OUT_W-1:0] q_r   [e2q_pkg::NUM_QUAT];
  logic signed [e2q_pkg::OUT_W-1:0] q_nxt [e2q_pkg::NUM_QUAT];

  // Round the Q32 CORDIC outputs to Q30.
  always_comb begin
    logic signed [e2q_pkg::CW-1:0] ty;
    logic signed [e2q_pkg::CW-1:0] tx;
    for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
      ty = (beat_in.lanes[a].y + e2q_pkg::SC_RND) >>> e2q_pkg::SC_SHIFT;
      tx = (beat_in.lanes[a].x + e2q_pkg::SC_RND) >>> e2q_pkg::SC_SHIFT;
      sin_nxt[a] = ty[e2q_pkg::SC_W-1:0];
      cos_nxt[a] = tx[e2q_pkg::SC_W-1:0];
    end
  end

  // Round the pitch-yaw products back to Q30.
  always_comb begin
    logic signed [e2q_pkg::PW-1:0] tr;
    for (int k = 0; k < e2q_pkg::NUM_QUAT; k++) begin
      tr = (m_r[k] + e2q_pkg::AB_RND) >>> e2q_pkg::AB_SHIFT;
      ab_nxt[k] = tr[e2q_pkg::SC_W-1:0];
    end
  end

  // Saturate each component to plus or minus one.
  always_comb begin
    logic signed [e2q_pkg::QW-1:0] c;
    for (int k = 0; k < e2q_pkg::NUM_QUAT; k++) begin
      c = rs_r[k];
      if (c > ONE_Q) begin
        c = ONE_Q;
      end else if (c < NEG_ONE_Q) begin
        c = NEG_ONE_Q;
      end
      q_nxt[k] = c[e2q_pkg::OUT_W-1:0];
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_ST-2:0], beat_in.valid};
    end
  end

  // Datapath registers, advanced as one pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      // Half-angle sines and cosines.
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;

      // Pitch-yaw products.
      m_r[0] <= sin_r[e2q_pkg::AX_PITCH] * sin_r[e2q_pkg::AX_YAW];
      m_r[1] <= cos_r[e2q_pkg::AX_PITCH] * cos_r[e2q_pkg::AX_YAW];
      m_r[2] <= sin_r[e2q_pkg::AX_PITCH] * cos_r[e2q_pkg::AX_YAW];
      m_r[3] <= cos_r[e2q_pkg::AX_PITCH] * sin_r[e2q_pkg::AX_YAW];
      rs1_r  <= sin_r[e2q_pkg::AX_ROLL];
      rc1_r  <= cos_r[e2q_pkg::AX_ROLL];

      // Rounded pitch-yaw terms.
      ab_r  <= ab_nxt;
      rs2_r <= rs1_r;
      rc2_r <= rc1_r;

      // Products with the roll sine and cosine.
      t_r[0] <= ab_r[0] * rc2_r;
      t_r[1] <= ab_r[1] * rs2_r;
      t_r[2] <= ab_r[2] * rc2_r;
      t_r[3] <= ab_r[3] * rs2_r;
      t_r[4] <= ab_r[3] * rc2_r;
      t_r[5] <= ab_r[2] * rs2_r;
      t_r[6] <= ab_r[1] * rc2_r;
      t_r[7] <= ab_r[0] * rs2_r;

      // Component sums in Q60.
      sum_r[e2q_pkg::QC_X] <= e2q_pkg::QW'(t_r[0]) + e2q_pkg::QW'(t_r[1]);
      sum_r[e2q_pkg::QC_Y] <= e2q_pkg::QW'(t_r[2]) - e2q_pkg::QW'(t_r[3]);
      sum_r[e2q_pkg::QC_Z] <= e2q_pkg::QW'(t_r[4]) - e2q_pkg::QW'(t_r[5]);
      sum_r[e2q_pkg::QC_W] <= e2q_pkg::QW'(t_r[6]) + e2q_pkg::QW'(t_r[7]);

      // Round to the output fraction width.
      for (int k = 0; k < e2q_pkg::NUM_QUAT; k++) begin
        rs_r[k] <= (sum_r[k] + RND_Q) >>> SH;
      end

      // Saturated result.
      q_r <= q_nxt;
    end
  end

  assign beat_out.valid  = vld_r[NUM_ST-1];
  assign beat_out.quat.x = q_r[e2q_pkg::QC_X];
  assign beat_out.quat.y = q_r[e2q_pkg::QC_Y];
  assign beat_out.quat.z = q_r[e2q_pkg::QC_Z];
  assign beat_out.quat.w = q_r[e2q_pkg::QC_W];

endmodule

FILE: rtl/core/e2q_out_skid.sv
// Output register with a skid stage between the pipeline and the result channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module e2q_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  e2q_pkg::quat_beat_t  p_beat,
  output logic                 p_ready,
  output e2q_pkg::quat_beat_t  out_beat,
  input  logic                 out_ready
);

  logic            out_valid_r;
  logic            out_valid_nxt;
  e2q_pkg::quat_t  out_data_r;
  e2q_pkg::quat_t  out_data_nxt;
  logic            skid_valid_r;
  logic            skid_valid_nxt;
  e2q_pkg::quat_t  skid_data_r;
  logic            skid_load;

  // The pipeline advances only while the skid slot is free.
  assign p_ready = !skid_valid_r;

  // Route the pipeline beat and the skid beat to the output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_load      = 1'b0;
    priority if (skid_valid_r) begin
      if (out_ready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (p_beat.valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = p_beat.quat;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_load      = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (skid_load) begin
      skid_data_r <= p_beat.quat;
    end
  end

  assign out_beat.valid = out_valid_r;
  assign out_beat.quat  = out_data_r;

  // The skid slot only fills behind a waiting output beat.
  `E2Q_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid beat without output beat")
  // A taken output drains the skid slot.
  `E2Q_ASSERT_NXT(a_skid_drain, clk, rst_n, skid_valid_r && out_ready, !skid_valid_r, "skid slot did not drain")
  // A pipeline beat arriving at a stalled output is parked, not dropped.
  `E2Q_ASSERT_NXT(a_skid_park, clk, rst_n, p_beat.valid && p_ready && out_valid_r && !out_ready, skid_valid_r, "pipeline beat dropped")

endmodule

FILE: sim/euler_to_quaternion_test.sv
// Self-checking testbench for the Euler-to-quaternion converter.
`timescale 1ns / 1ps

module euler_to_quaternion_test;
  import e2q_pkg::*;

  localparam int ANGLE_BITS    = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 8;
  localparam int RANDOM_PER_PHASE = 643;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
  } angle_set_t;

  // One outstanding quaternion, kept with the angles that produced it.
  typedef struct {
    angle_set_t angles;
    quat_t      quat;
  } pending_quat_t;

  // Directed beats: zeros, single-axis quarter and half turns, extremes of the
  // signed range, alternating bit patterns and mixed signs. A quarter turn
  // leaves an exactly zero residual after the first rotation, and the small
  // angles push W onto the saturation limit.
  localparam int NUM_DIRECTED = 21;
  localparam angle_set_t DIRECTED_ANGLES [NUM_DIRECTED] = '{
    '{16'h0000, 16'h0000, 16'h0000},
    '{16'h4000, 16'h0000, 16'h0000},
    '{16'h0000, 16'h4000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h4000},
    '{16'hC000, 16'hC000, 16'hC000},
    '{16'h8000, 16'h0000, 16'h0000},
    '{16'h0000, 16'h8000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h8000},
    '{16'h8000, 16'h8000, 16'h8000},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF},
    '{16'h8000, 16'h7FFF, 16'h0001},
    '{16'h7FFF, 16'h8000, 16'h7FFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h0001, 16'h0001, 16'h0001},
    '{16'h0001, 16'hFFFF, 16'h0001},
    '{16'h5555, 16'hAAAA, 16'h5555},
    '{16'hAAAA, 16'h5555, 16'hAAAA},
    '{16'h2000, 16'h2000, 16'h2000},
    '{16'hE000, 16'h2000, 16'hC000},
    '{16'h4000, 16'hC000, 16'h8000},
    '{16'h3FFF, 16'hC001, 16'h4001}
  };

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;

  pending_quat_t pending_quats [$];

  e2q_angle_if angle_ch ();
  e2q_quat_if  quat_ch ();

  euler_to_quaternion #(
    .ANGLE_BITS   (ANGLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (angle_ch),
    .out_if(quat_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Half-angle sine and cosine in Q30 from a rotation-mode CORDIC. The angle
  // accumulator counts a full turn as 2^33, so the input scaled by 2^16 is
  // already the half-angle.
  function automatic void half_angle_sincos(input logic signed [ANGLE_W-1:0] ang,
                                            output longint sin_q30,
                                            output longint cos_q30);
    longint vx;
    longint vy;
    longint resid;
    longint step_x;
    longint step_y;
    longint step_a;
    vx    = longint'(CORDIC_K_Q32);
    vy    = 0;
    resid = longint'(ang) <<< (32 - ANGLE_BITS);
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      step_x = vy >>> i;
      step_y = vx >>> i;
      step_a = 2 * longint'(ATAN_TURN32[i]);
      // A residual of exactly zero still rotates the positive way.
      if (resid >= 0) begin
        vx    -= step_x;
        vy    += step_y;
        resid -= step_a;
      end else begin
        vx    += step_x;
        vy    -= step_y;
        resid += step_a;
      end
    end
    sin_q30 = (vy + 2) >>> 2;
    cos_q30 = (vx + 2) >>> 2;
  endfunction

  // Product of three Q30 values in Q60, the first pair rounded back to Q30.
  function automatic longint product_q60(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b + (longint'(1) <<< 29)) >>> 30;
    return ab * c;
  endfunction

  // Q60 sum rounded to the output format and saturated to plus or minus one.
  function automatic logic signed [OUT_W-1:0] round_component(input longint q60);
    longint r;
    longint one;
    one = longint'(1) <<< FRAC_BITS;
    r   = (q60 + (longint'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OUT_W-1:0];
  endfunction

  function automatic quat_t quat_from_euler(input angle_set_t a);
    longint s_r, c_r, s_p, c_p, s_y, c_y;
    quat_t q;
    half_angle_sincos(a.roll, s_r, c_r);
    half_angle_sincos(a.pitch, s_p, c_p);
    half_angle_sincos(a.yaw, s_y, c_y);
    q.x = round_component(product_q60(s_p, s_y, c_r) + product_q60(c_p, c_y, s_r));
    q.y = round_component(product_q60(s_p, c_y, c_r) - product_q60(c_p, s_y, s_r));
    q.z = round_component(product_q60(c_p, s_y, c_r) - product_q60(s_p, c_y, s_r));
    q.w = round_component(product_q60(c_p, c_y, c_r) + product_q60(s_p, s_y, s_r));
    return q;
  endfunction

  // Random angle: mostly uniform, sometimes near zero or 1/8, 1/4 or 1/2 turn.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    logic [ANGLE_W-1:0] corners [6];
    corners = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h2000};
    if ($urandom_range(7) == 0)
      return corners[$urandom_range(5)] + ANGLE_W'($urandom_range(8)) - 16'd4;
    return ANGLE_W'($urandom);
  endfunction

  // Present one beat after a random number of idle cycles and hold it until
  // the block takes it. Called and returning on a falling edge.
  task automatic send_angles(input angle_set_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid       <= 1'b0;
      angle_ch.roll_angle  <= ANGLE_W'($urandom);
      angle_ch.pitch_angle <= ANGLE_W'($urandom);
      angle_ch.yaw_angle   <= ANGLE_W'($urandom);
      @(negedge clk);
    end
    angle_ch.valid       <= 1'b1;
    angle_ch.roll_angle  <= a.roll;
    angle_ch.pitch_angle <= a.pitch;
    angle_ch.yaw_angle   <= a.yaw;
    do @(posedge clk); while (!angle_ch.ready);
    @(negedge clk);
  endtask

  // Hold the input quiet until every outstanding quaternion has come back.
  task automatic drain_results();
    angle_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_quats.size() != 0);
  endtask

  task automatic send_random(input int count);
    angle_set_t a;
    for (int n = 0; n < count; n++) begin
      a.roll  = random_angle();
      a.pitch = random_angle();
      a.yaw   = random_angle();
      send_angles(a);
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    quat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted input beat queues its predicted quaternion.
  always @(posedge clk) begin : record_inputs
    pending_quat_t entry;
    if (rst_n && angle_ch.valid && angle_ch.ready) begin
      entry.angles = '{angle_ch.roll_angle, angle_ch.pitch_angle, angle_ch.yaw_angle};
      entry.quat   = quat_from_euler(entry.angles);
      pending_quats.push_back(entry);
    end
  end

  // Every accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin : check_outputs
    pending_quat_t want;
    logic signed [OUT_W-1:0] got_f [4];
    logic signed [OUT_W-1:0] want_f [4];
    string comp_names [4];
    comp_names = '{"x", "y", "z", "w"};
    if (rst_n && quat_ch.valid && quat_ch.ready) begin
      if (pending_quats.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected quaternion beat x=%0d y=%0d z=%0d w=%0d", quat_ch.quat_x,
                   quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w);
        mismatches++;
      end else begin
        want   = pending_quats.pop_front();
        got_f  = '{quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w};
        want_f = '{want.quat.x, want.quat.y, want.quat.z, want.quat.w};
        for (int k = 0; k < 4; k++) begin
          if (got_f[k] !== want_f[k]) begin
            if (mismatches < 10)
              $display("quat_%s mismatch for roll=%0d pitch=%0d yaw=%0d: expected %0d, got %0d",
                       comp_names[k], want.angles.roll, want.angles.pitch, want.angles.yaw,
                       want_f[k], got_f[k]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    mismatches           = 0;
    send_idle_pct        = 7;
    recv_idle_pct        = 51;
    rst_n                = 1'b0;
    angle_ch.valid       = 1'b0;
    angle_ch.roll_angle  = '0;
    angle_ch.pitch_angle = '0;
    angle_ch.yaw_angle   = '0;
    quat_ch.ready        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats, then the first random phase: sender mostly busy,
    // receiver stalling about half the time.
    for (int n = 0; n < NUM_DIRECTED; n++)
      send_angles(DIRECTED_ANGLES[n]);
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Sender idles often, receiver rarely stalls.
    send_idle_pct = 51;
    recv_idle_pct = 7;
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Let any stray beat still in the pipeline show up.
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && pending_quats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: euler_to_quaternion.f
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_angle_if.sv
rtl/core/e2q_quat_if.sv
rtl/core/e2q_cordic_cell.sv
rtl/core/e2q_quat_math.sv
rtl/core/e2q_out_skid.sv
rtl/core/euler_to_quaternion.sv
sim/euler_to_quaternion_test.sv
